/* design/alt_pkg.sv */
// Package for the arc length table and u-to-t mapper.
// Holds the input/result transfer structs and command/status codes.
// No dependencies.
package alt_pkg;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QFRAC  = 2'd2;
    localparam logic [1:0] CMD_QDIST  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTREADY = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [16:0]        fraction_u;
        logic [47:0]        target_distance;
    } t_in;

    typedef struct packed {
        logic [16:0] param_t;
        logic [47:0] running_length;
        logic [1:0]  status;
    } t_out;

endpackage

/* design/alt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module alt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/arc_length_table_and_u_to_t_map.sv */
// Arc length table builder and length-to-parameter mapper (top level).
// Depends on alt_pkg and alt_ram.
// Start, table full and not ready answer straight from idle; an append runs 3 multiplies
// and a 35-step root; a query runs a binary search (8 or 9 steps at 256 entries), then two
// 64-step dividers, or one on an exact entry hit; a saturated query stops at the first search step.
// One item at a time: the next transfer is taken at the edge ending the strobe.
// Synchronous active-low reset clears counters and sums; table is undefined. No output stall.
module arc_length_table_and_u_to_t_map #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  alt_pkg::t_in    i_item,
    output logic            o_valid,
    output alt_pkg::t_out   o_result,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // state codes
    localparam logic [4:0] S_IDLE = 5'd0, S_MUL = 5'd1, S_SQRT = 5'd2,
        S_WR = 5'd3, S_TOT = 5'd4, S_TGT = 5'd5, S_SRCH = 5'd6,
        S_SRCHW = 5'd7, S_RDA = 5'd8, S_RDB = 5'd9, S_RDBW = 5'd10,
        S_DIV1 = 5'd11, S_DIV2 = 5'd12, S_DONE = 5'd13, S_WRB = 5'd14,
        S_RDX = 5'd15, S_RDY = 5'd16, S_DIV1I = 5'd17, S_DIV2I = 5'd18,
        S_FIN = 5'd19;

    logic [4:0]  r_state;
    logic [7:0]  r_div;
    logic [CW-1:0] r_count;
    logic [31:0] r_px, r_py, r_pz;
    logic [47:0] r_sum;
    alt_pkg::t_in r_in;
    alt_pkg::t_out r_res;
    logic        r_valid;

    // working registers
    logic [65:0] r_sq;
    logic [1:0]  r_mstep;
    logic [34:0] r_root;
    logic [5:0]  r_bit;
    logic [47:0] r_total, r_target, r_base, r_seg;
    logic [CW-1:0] r_lo, r_hi;
    logic [AW-1:0] r_idx;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [47:0] r_dvs;
    logic [6:0]  r_dcnt;
    logic [CW-1:0] r_need;

    // ram port
    logic          n_we;
    logic [AW-1:0] n_waddr, n_raddr;
    logic [47:0]   n_wdata, rdata;

    alt_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_tab (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_waddr), .i_wdata(n_wdata),
        .i_raddr(n_raddr), .o_rdata(rdata)
    );

    // needed entries
    logic [8:0] need9;
    always_comb begin
        need9 = (r_div == 8'd0) ? 9'd2 : {1'b0, r_div} + 9'd1;
    end
    logic [CW-1:0] need;
    assign need = (32'(need9) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(need9);

    // absolute differences
    function automatic logic [31:0] absd(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        begin
            d = $signed({a[31], a}) - $signed({b[31], b});
            absd = d[32] ? 32'(-d) : d[31:0];
        end
    endfunction

    logic [31:0] mop;
    always_comb begin
        unique case (r_mstep)
            2'd0: mop = absd(r_in.point_x, r_px);
            2'd1: mop = absd(r_in.point_y, r_py);
            default: mop = absd(r_in.point_z, r_pz);
        endcase
    end
    logic [63:0] mprod;
    assign mprod = mop * mop;

    // root trial: c*c <= sq
    logic [34:0] cand;
    logic [69:0] csq;
    assign cand = r_root | (35'd1 << r_bit);
    assign csq = cand * cand;

    logic [48:0] nsum;
    assign nsum = {1'b0, r_sum} + {14'd0, r_root};

    // divider step
    logic [64:0] dtrial;
    assign dtrial = {r_rem, r_quo[63]} - {17'd0, r_dvs};

    logic [CW-1:0] mid;
    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    logic [64:0] uprod;
    assign uprod = r_in.fraction_u * r_total;

    always_comb begin
        n_we = 1'b0;
        n_waddr = r_count[AW-1:0];
        n_wdata = r_sum;
        n_raddr = mid[AW-1:0];
        if (r_state == S_IDLE && start) begin
            n_we = (i_item.command == alt_pkg::CMD_START);
            n_waddr = '0;
            n_wdata = '0;
        end else if (r_state == S_WRB) begin
            n_we = 1'b1;
            n_wdata = r_sum;
        end
        unique case (r_state)
            S_IDLE:  n_raddr = AW'(need - CW'(1));
            S_RDA:   n_raddr = r_idx;
            S_RDB:   n_raddr = r_idx - AW'(1);
            S_RDX:   n_raddr = r_idx + AW'(1);
            default: n_raddr = mid[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_div <= 8'd200;
            r_count <= '0;
            r_px <= '0; r_py <= '0; r_pz <= '0;
            r_sum <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_DONE);
            if (i_cfg_we) begin
                r_div <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in <= i_item;
                        r_need <= need;
                        r_res.param_t <= '0;
                        unique case (i_item.command)
                            alt_pkg::CMD_START: begin
                                r_count <= CW'(1);
                                r_sum <= '0;
                                r_px <= i_item.point_x;
                                r_py <= i_item.point_y;
                                r_pz <= i_item.point_z;
                                r_res.running_length <= '0;
                                r_res.status <= alt_pkg::ST_OK;
                                r_state <= S_DONE;
                            end
                            alt_pkg::CMD_APPEND: begin
                                r_res.running_length <= r_sum;
                                if (r_count == '0) begin
                                    r_res.status <= alt_pkg::ST_NOTREADY;
                                    r_state <= S_DONE;
                                end else if (r_count >= need) begin
                                    r_res.status <= alt_pkg::ST_FULL;
                                    r_state <= S_DONE;
                                end else begin
                                    r_res.status <= alt_pkg::ST_OK;
                                    r_sq <= '0;
                                    r_mstep <= 2'd0;
                                    r_state <= S_MUL;
                                end
                            end
                            default: begin
                                r_res.running_length <= r_sum;
                                if (r_count != need) begin
                                    r_res.status <= alt_pkg::ST_NOTREADY;
                                    r_state <= S_DONE;
                                end else begin
                                    r_res.status <= alt_pkg::ST_OK;
                                    r_state <= S_TOT;
                                end
                            end
                        endcase
                    end
                end
                // sum of squares, one multiply a cycle
                S_MUL: begin
                    r_sq <= r_sq + {2'd0, mprod};
                    if (r_mstep == 2'd2) begin
                        r_root <= '0;
                        r_bit <= 6'd34;
                        r_state <= S_SQRT;
                    end
                    r_mstep <= r_mstep + 2'd1;
                end
                // bitwise square root, one bit a cycle
                S_SQRT: begin
                    if (csq <= {4'd0, r_sq}) begin
                        r_root <= cand;
                    end
                    if (r_bit == 6'd0) begin
                        r_state <= S_WR;
                    end
                    r_bit <= r_bit - 6'd1;
                end
                S_WR: begin
                    r_sum <= nsum[48] ? alt_pkg::MAX48 : nsum[47:0];
                    r_state <= S_WRB;
                end
                S_WRB: begin
                    // written in this cycle at old count
                    r_count <= r_count + CW'(1);
                    r_px <= r_in.point_x;
                    r_py <= r_in.point_y;
                    r_pz <= r_in.point_z;
                    r_res.running_length <= r_sum;
                    r_state <= S_DONE;
                end
                S_TOT: begin
                    r_total <= rdata;
                    r_state <= S_TGT;
                end
                S_TGT: begin
                    r_res.running_length <= r_total;
                    if (r_in.command == alt_pkg::CMD_QFRAC) begin
                        r_target <= (r_in.fraction_u > alt_pkg::ONE_Q16)
                            ? r_total : uprod[63:16];
                    end else begin
                        r_target <= r_in.target_distance;
                    end
                    r_lo <= '0;
                    r_hi <= r_need;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_target > r_total) begin
                        r_res.param_t <= alt_pkg::ONE_Q16;
                        r_res.status <= alt_pkg::ST_SAT;
                        r_state <= S_DONE;
                    end else if (r_lo < r_hi) begin
                        r_state <= S_SRCHW;
                    end else begin
                        r_idx <= r_lo[AW-1:0];
                        r_state <= S_RDA;
                    end
                end
                S_SRCHW: begin
                    if (rdata < r_target) r_lo <= mid + CW'(1);
                    else r_hi <= mid;
                    r_state <= S_SRCH;
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                // entry at the found index; a hit skips interpolation and divides the index by the last index
                S_RDB: begin
                    if (rdata == r_target) begin
                        r_rem <= '0;
                        r_quo <= {32'd0, 16'(r_idx), 16'd0};
                        r_dvs <= 48'(r_need - CW'(1));
                        r_dcnt <= 7'd64;
                        r_state <= S_DIV2;
                    end else begin
                        r_idx <= r_idx - AW'(1);
                        r_state <= S_RDBW;
                    end
                end
                S_RDBW: begin
                    r_base <= rdata;
                    r_state <= S_RDX;
                end
                S_RDX: begin
                    r_state <= S_RDY;
                end
                S_RDY: begin
                    r_seg <= rdata - r_base;
                    r_state <= S_DIV1I;
                end
                S_DIV1I: begin
                    r_rem <= '0;
                    r_quo <= {(r_target - r_base), 16'd0};
                    r_dvs <= r_seg;
                    r_dcnt <= 7'd64;
                    r_state <= S_DIV1;
                end
                // restoring divide, one bit a cycle
                S_DIV1, S_DIV2: begin
                    if (!dtrial[64]) begin
                        r_rem <= dtrial[63:0];
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_quo[63]};
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 7'd1;
                    if (r_dcnt == 7'd1) begin
                        r_state <= (r_state == S_DIV1) ? S_DIV2I : S_FIN;
                    end
                end
                S_DIV2I: begin
                    r_quo <= {32'd0, 16'(r_idx), 16'd0} + r_quo;
                    r_rem <= '0;
                    r_dvs <= 48'(r_need - CW'(1));
                    r_dcnt <= 7'd64;
                    r_state <= S_DIV2;
                end
                S_FIN: begin
                    r_res.param_t <= r_quo[16:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_result = r_res;
endmodule
